// ----- rtl/core/vlts_pkg.sv -----
// Shared constants, types and register codes for the volume line tube sum block.
`timescale 1ns / 1ps

package vlts_pkg;

    localparam int MAX_DIM = 1024;
    localparam int COORD_W = $clog2(MAX_DIM);

    localparam int VAL_W  = 8;
    localparam int SIZE_W = 11;
    localparam int PT_W   = 20;
    localparam int DIR_W  = 16;
    localparam int SUM_W  = 38;
    localparam int SUMX_W = SUM_W + 1;

    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int REG_IW = 3;

    // Counter compare width: holds coordinate + 1, the size and MAX_DIM.
    localparam int CNT_W = ((COORD_W + 1) > SIZE_W) ? (COORD_W + 1) : SIZE_W;

    // Datapath widths, each just wide enough for exact integer arithmetic.
    localparam int FRAC_SHIFT = 14;
    localparam int RND_HALF   = 1 << (FRAC_SHIFT - 1);
    localparam int ONE_Q16    = 1 << 16;
    localparam int D_W   = (((COORD_W + 9) > PT_W) ? (COORD_W + 9) : PT_W) + 1;
    localparam int P_W   = D_W + DIR_W;
    localparam int S_W   = P_W + 3;
    localparam int T_W   = S_W - FRAC_SHIFT;
    localparam int Q_W   = T_W + DIR_W;
    localparam int QS_W  = Q_W + 1;
    localparam int QR_W  = QS_W - FRAC_SHIFT;
    localparam int R_W   = ((D_W > QR_W) ? D_W : QR_W) + 1;
    localparam int SQ_W  = 2 * R_W;
    localparam int D2_W  = SQ_W + 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [SIZE_W-1:0]       X_SIZE_RST = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0]       Y_SIZE_RST = SIZE_W'(1024);
    localparam logic signed [DIR_W-1:0] DIR_X_RST  = DIR_W'(16384);

    typedef enum logic [REG_IW-1:0] {
        REG_X_SIZE = 3'd0,
        REG_Y_SIZE = 3'd1,
        REG_PT_X   = 3'd2,
        REG_PT_Y   = 3'd3,
        REG_PT_Z   = 3'd4,
        REG_DIR_X  = 3'd5,
        REG_DIR_Y  = 3'd6,
        REG_DIR_Z  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] x_size;
        logic [SIZE_W-1:0] y_size;
    } t_geo_cfg;

    typedef struct packed {
        logic signed [PT_W-1:0]  pt_x;
        logic signed [PT_W-1:0]  pt_y;
        logic signed [PT_W-1:0]  pt_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } t_line_cfg;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic               last;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
    } t_entry;

    typedef struct packed {
        logic push;
        logic full;
    } t_push_ctl;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_pop_ctl;

endpackage

// ----- rtl/core/vlts_vox_if.sv -----
// Voxel input channel: valid/ready handshake with one voxel byte per request.
`timescale 1ns / 1ps

interface vlts_vox_if;
    import vlts_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] voxel_value;
    logic             last_voxel;

    modport source(output valid, voxel_value, last_voxel, input ready);
    modport sink(input valid, voxel_value, last_voxel, output ready);
endinterface

// ----- rtl/core/vlts_sum_if.sv -----
// Result channel: valid/ready handshake carrying one line sum per request.
`timescale 1ns / 1ps

interface vlts_sum_if;
    import vlts_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] line_sum;

    modport source(output valid, line_sum, input ready);
    modport sink(input valid, line_sum, output ready);
endinterface

// ----- rtl/core/volume_line_tube_sum.sv -----
// Top level: APB register file, front end, request queue and distance back end.
// A last voxel's sum is posted to o_sum from the result register after the queue and the distance pipeline.
// Throughput: one voxel per cycle while the queue has room; the distance pipeline advances every cycle
// unless a finished sum waits at the output, and a 4-entry queue absorbs that stall.
// Reset (synchronous, active low) clears coordinates, sum, queue and valid bits
// and loads the register defaults: sizes 1024, point 0, direction +x.
`timescale 1ns / 1ps

module volume_line_tube_sum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    vlts_vox_if.sink                     i_vox,
    vlts_sum_if.source                   o_sum,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vlts_pkg::APB_AW-1:0]  paddr,
    input  logic [vlts_pkg::APB_DW-1:0]  pwdata,
    output logic [vlts_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import vlts_pkg::*;

    logic [SIZE_W-1:0]       r_x_size, r_y_size;
    logic signed [PT_W-1:0]  r_pt_x, r_pt_y, r_pt_z;
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y, r_dir_z;
    t_reg_idx                w_idx;
    logic                    w_wr;
    t_geo_cfg                w_geo;
    t_line_cfg               w_line;
    t_entry                  w_in_entry, w_out_entry;
    t_push_ctl               w_push_ctl;
    t_pop_ctl                w_pop_ctl;
    logic                    w_push, w_pop;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= X_SIZE_RST;
            r_y_size <= Y_SIZE_RST;
            r_pt_x   <= '0;
            r_pt_y   <= '0;
            r_pt_z   <= '0;
            r_dir_x  <= DIR_X_RST;
            r_dir_y  <= '0;
            r_dir_z  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_X_SIZE: r_x_size <= pwdata[SIZE_W-1:0];
                REG_Y_SIZE: r_y_size <= pwdata[SIZE_W-1:0];
                REG_PT_X:   r_pt_x   <= $signed(pwdata[PT_W-1:0]);
                REG_PT_Y:   r_pt_y   <= $signed(pwdata[PT_W-1:0]);
                REG_PT_Z:   r_pt_z   <= $signed(pwdata[PT_W-1:0]);
                REG_DIR_X:  r_dir_x  <= $signed(pwdata[DIR_W-1:0]);
                REG_DIR_Y:  r_dir_y  <= $signed(pwdata[DIR_W-1:0]);
                REG_DIR_Z:  r_dir_z  <= $signed(pwdata[DIR_W-1:0]);
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_X_SIZE: prdata = APB_DW'(r_x_size);
            REG_Y_SIZE: prdata = APB_DW'(r_y_size);
            REG_PT_X:   prdata = APB_DW'($unsigned(r_pt_x));
            REG_PT_Y:   prdata = APB_DW'($unsigned(r_pt_y));
            REG_PT_Z:   prdata = APB_DW'($unsigned(r_pt_z));
            REG_DIR_X:  prdata = APB_DW'($unsigned(r_dir_x));
            REG_DIR_Y:  prdata = APB_DW'($unsigned(r_dir_y));
            REG_DIR_Z:  prdata = APB_DW'($unsigned(r_dir_z));
        endcase
    end

    assign w_geo.x_size = r_x_size;
    assign w_geo.y_size = r_y_size;
    assign w_line.pt_x  = r_pt_x;
    assign w_line.pt_y  = r_pt_y;
    assign w_line.pt_z  = r_pt_z;
    assign w_line.dir_x = r_dir_x;
    assign w_line.dir_y = r_dir_y;
    assign w_line.dir_z = r_dir_z;

    vlts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vox   (i_vox),
        .i_geo   (w_geo),
        .i_full  (w_push_ctl.full),
        .o_push  (w_push),
        .o_entry (w_in_entry)
    );

    vlts_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_entry    (w_in_entry),
        .i_pop      (w_pop),
        .o_push_ctl (w_push_ctl),
        .o_pop_ctl  (w_pop_ctl),
        .o_entry    (w_out_entry)
    );

    vlts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (w_line),
        .i_entry (w_out_entry),
        .i_empty (w_pop_ctl.empty),
        .o_pop   (w_pop),
        .o_sum   (o_sum)
    );

    a_pop_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_ctl.pop == w_pop)
        else $error("back end popped an empty queue");

endmodule

// ----- rtl/core/vlts_front.sv -----
// Front end: accepts voxel requests and tags each with its x, y, z position.
`timescale 1ns / 1ps

module vlts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vlts_vox_if.sink           i_vox,
    input  vlts_pkg::t_geo_cfg i_geo,
    input  logic               i_full,
    output logic               o_push,
    output vlts_pkg::t_entry   o_entry
);
    import vlts_pkg::*;

    logic [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [COORD_W-1:0] n_cx, n_cy, n_cz;
    logic [CNT_W-1:0]   w_nx, w_ny, w_nz;
    logic               w_wrap_x, w_wrap_y, w_wrap_z;
    logic               w_acc;

    assign i_vox.ready = !i_full;
    assign w_acc       = i_vox.valid && !i_full;
    assign o_push      = w_acc;

    assign o_entry.value = i_vox.voxel_value;
    assign o_entry.last  = i_vox.last_voxel;
    assign o_entry.cx    = r_cx;
    assign o_entry.cy    = r_cy;
    assign o_entry.cz    = r_cz;

    // A size of zero behaves like one since the compare wraps at once.
    always_comb begin
        w_nx = CNT_W'(r_cx) + CNT_W'(1);
        w_ny = CNT_W'(r_cy) + CNT_W'(1);
        w_nz = CNT_W'(r_cz) + CNT_W'(1);
        w_wrap_x = (w_nx >= CNT_W'(i_geo.x_size)) || (w_nx >= CNT_W'(MAX_DIM));
        w_wrap_y = (w_ny >= CNT_W'(i_geo.y_size)) || (w_ny >= CNT_W'(MAX_DIM));
        w_wrap_z = (w_nz >= CNT_W'(MAX_DIM));

        n_cx = r_cx;
        n_cy = r_cy;
        n_cz = r_cz;
        if (w_acc) begin
            if (i_vox.last_voxel) begin
                n_cx = '0;
                n_cy = '0;
                n_cz = '0;
            end else begin
                n_cx = w_wrap_x ? '0 : COORD_W'(w_nx);
                if (w_wrap_x) begin
                    n_cy = w_wrap_y ? '0 : COORD_W'(w_ny);
                    if (w_wrap_y) begin
                        n_cz = w_wrap_z ? '0 : COORD_W'(w_nz);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
        end else begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
        end
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vox.valid && i_vox.ready && i_vox.last_voxel)
            |=> (r_cx == '0 && r_cy == '0 && r_cz == '0))
        else $error("coordinates not cleared after last voxel");

    a_y_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_vox.last_voxel && !w_wrap_x) |=> $stable(r_cy) && $stable(r_cz))
        else $error("row or slice counter moved without a row wrap");

endmodule

// ----- rtl/core/vlts_queue.sv -----
// Short request queue between the front end and the distance datapath.
`timescale 1ns / 1ps

module vlts_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vlts_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output vlts_pkg::t_push_ctl o_push_ctl,
    output vlts_pkg::t_pop_ctl  o_pop_ctl,
    output vlts_pkg::t_entry    o_entry
);
    import vlts_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              w_full, w_empty, w_push, w_pop;

    assign w_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign w_empty = (r_count == '0);
    assign w_push  = i_push && !w_full;
    assign w_pop   = i_pop && !w_empty;

    assign o_push_ctl.push = w_push;
    assign o_push_ctl.full = w_full;
    assign o_pop_ctl.pop   = w_pop;
    assign o_pop_ctl.empty = w_empty;
    assign o_entry         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W + 1)'(w_push) - (QPTR_W + 1)'(w_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W + 1)'(QDEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && w_full))
        else $error("push offered to a full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wr - r_rd) == QPTR_W'(r_count))
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/vlts_back.sv -----
// Back end: distance-to-line pipeline, tube test, saturating sum and result register.
`timescale 1ns / 1ps

module vlts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vlts_pkg::t_line_cfg i_line,
    input  vlts_pkg::t_entry    i_entry,
    input  logic                i_empty,
    output logic                o_pop,
    vlts_sum_if.source          o_sum
);
    import vlts_pkg::*;

    logic signed [PT_W-1:0]  w_pt  [3];
    logic signed [DIR_W-1:0] w_dir [3];
    logic [COORD_W-1:0]      w_c   [3];
    logic signed [D_W-1:0]   w_d   [3];
    logic signed [P_W-1:0]   w_p   [3];
    logic signed [S_W-1:0]   w_s;
    logic signed [Q_W-1:0]   w_qp  [3];
    logic signed [QS_W-1:0]  w_qs  [3];
    logic signed [R_W-1:0]   w_r   [3];
    logic signed [SQ_W-1:0]  w_sq  [3];
    logic [D2_W-1:0]         w_d2;
    logic [SUMX_W-1:0]       w_add;
    logic [SUM_W-1:0]        w_sat;
    logic                    w_en;

    // Stage registers: 1 offsets and first products, 2 projection, 3 second
    // products, 4 perpendicular remainder, 5 squares, 6 tube hit.
    logic                    r_v   [7];
    logic [VAL_W-1:0]        r_val [7];
    logic                    r_last[7];
    logic signed [D_W-1:0]   r1_d  [3];
    logic signed [P_W-1:0]   r1_p  [3];
    logic signed [D_W-1:0]   r2_d  [3];
    logic signed [T_W-1:0]   r2_t;
    logic signed [D_W-1:0]   r3_d  [3];
    logic signed [Q_W-1:0]   r3_qp [3];
    logic signed [R_W-1:0]   r4_r  [3];
    logic signed [SQ_W-1:0]  r5_sq [3];
    logic                    r6_hit;
    logic [SUM_W-1:0]        r_run_sum;
    logic                    r_out_valid;
    logic [SUM_W-1:0]        r_out_sum;

    // The whole pipeline holds only when a finished sum cannot be handed over.
    assign w_en  = !(r_v[6] && r_last[6]) || !r_out_valid || o_sum.ready;
    assign o_pop = w_en && !i_empty;

    assign o_sum.valid    = r_out_valid;
    assign o_sum.line_sum = r_out_sum;

    always_comb begin
        w_pt[0]  = i_line.pt_x;
        w_pt[1]  = i_line.pt_y;
        w_pt[2]  = i_line.pt_z;
        w_dir[0] = i_line.dir_x;
        w_dir[1] = i_line.dir_y;
        w_dir[2] = i_line.dir_z;
        w_c[0]   = i_entry.cx;
        w_c[1]   = i_entry.cy;
        w_c[2]   = i_entry.cz;
        for (int i = 0; i < 3; i++) begin
            w_d[i]  = D_W'(w_pt[i]) - D_W'($signed({1'b0, w_c[i], 8'b0}));
            w_p[i]  = P_W'(w_d[i]) * P_W'(w_dir[i]);
            w_qp[i] = Q_W'(r2_t) * Q_W'(w_dir[i]);
            w_qs[i] = QS_W'(r3_qp[i]) + QS_W'(RND_HALF);
            w_r[i]  = R_W'(r3_d[i]) - R_W'(QR_W'(w_qs[i] >>> FRAC_SHIFT));
            w_sq[i] = SQ_W'(r4_r[i]) * SQ_W'(r4_r[i]);
        end
        w_s = S_W'(r1_p[0]) + S_W'(r1_p[1]) + S_W'(r1_p[2]) + S_W'(RND_HALF);
        // Squares are non-negative, so their top bit is clear.
        w_d2 = D2_W'($unsigned(r5_sq[0])) + D2_W'($unsigned(r5_sq[1]))
             + D2_W'($unsigned(r5_sq[2]));
        w_add = SUMX_W'(r_run_sum) + (r6_hit ? SUMX_W'(r_val[6]) : '0);
        w_sat = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
    end

    // Datapath registers advance together with the valid bits.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_val[1]  <= i_entry.value;
            r_last[1] <= i_entry.last;
            for (int s = 2; s < 7; s++) begin
                r_val[s]  <= r_val[s-1];
                r_last[s] <= r_last[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                r1_d[i]  <= w_d[i];
                r1_p[i]  <= w_p[i];
                r2_d[i]  <= r1_d[i];
                r3_d[i]  <= r2_d[i];
                r3_qp[i] <= w_qp[i];
                r4_r[i]  <= w_r[i];
                r5_sq[i] <= w_sq[i];
            end
            r2_t   <= T_W'(w_s >>> FRAC_SHIFT);
            r6_hit <= (w_d2 < D2_W'(ONE_Q16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v[6] && r_last[6]) begin
            r_out_sum <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 7; s++) begin
                r_v[s] <= 1'b0;
            end
            r_run_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v[0] <= 1'b0;
            if (w_en) begin
                r_v[1] <= !i_empty;
                for (int s = 2; s < 7; s++) begin
                    r_v[s] <= r_v[s-1];
                end
                if (r_v[6]) begin
                    r_run_sum <= r_last[6] ? '0 : w_sat;
                end
            end
            if (w_en && r_v[6] && r_last[6]) begin
                r_out_valid <= 1'b1;
            end else if (o_sum.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_v[6] && r_last[6]) |=> (r_run_sum == '0 && r_out_valid))
        else $error("sum not cleared or result not posted after last voxel");

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && r_last[6] && r_out_valid && !o_sum.ready) |=> $stable(r_run_sum))
        else $error("running sum moved while the result was stalled");

endmodule

// ----- tb/sv/tb_volume_line_tube_sum.sv -----
// Self-checking testbench for the volume line tube sum block with a built-in line-distance predictor.
`timescale 1ns / 1ps

module tb_volume_line_tube_sum;
    import vlts_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_VOXELS = 120;
    localparam int WRAP_VOXELS   = 1026;
    localparam logic [SUM_W:0] SUM_CAP = {1'b0, {SUM_W{1'b1}}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    vlts_vox_if vox_if();
    vlts_sum_if sum_if();

    volume_line_tube_sum uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vox   (vox_if),
        .o_sum   (sum_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: register copies, coordinate counters and the running sum.
    t_geo_cfg         geo_cfg;
    t_line_cfg        line_cfg;
    int               pos_x;
    int               pos_y;
    int               pos_z;
    logic [SUM_W-1:0] tube_sum;

    logic [SUM_W-1:0] expected_sums[$];
    int               fail_count;
    bit               src_idle_en;
    bit               sink_idle_en;
    int               hold_seq;
    int               hold_len;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_volume_line_tube_sum: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int eff_size(logic [SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_DIM) return MAX_DIM;
        return int'(s);
    endfunction

    // floor((v + 2^13) / 2^14): the arithmetic shift already floors.
    function automatic longint round_q14(longint v);
        return (v + 64'sd8192) >>> FRAC_SHIFT;
    endfunction

    function automatic void accumulate_voxel(logic [VAL_W-1:0] value, logic last);
        longint dx, dy, dz, t, rx, ry, rz, d2;
        logic [SUM_W:0] wide;
        dx = longint'(line_cfg.pt_x) - longint'(pos_x) * 256;
        dy = longint'(line_cfg.pt_y) - longint'(pos_y) * 256;
        dz = longint'(line_cfg.pt_z) - longint'(pos_z) * 256;
        t  = round_q14(dx * longint'(line_cfg.dir_x) + dy * longint'(line_cfg.dir_y)
                       + dz * longint'(line_cfg.dir_z));
        rx = dx - round_q14(t * longint'(line_cfg.dir_x));
        ry = dy - round_q14(t * longint'(line_cfg.dir_y));
        rz = dz - round_q14(t * longint'(line_cfg.dir_z));
        d2 = rx * rx + ry * ry + rz * rz;
        if (d2 < longint'(ONE_Q16)) begin
            wide = {1'b0, tube_sum} + value;
            tube_sum = (wide > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : wide[SUM_W-1:0];
        end
        if (last) begin
            expected_sums.push_back(tube_sum);
            tube_sum = '0;
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
        end else begin
            pos_x++;
            if (pos_x >= eff_size(geo_cfg.x_size)) begin
                pos_x = 0;
                pos_y++;
                if (pos_y >= eff_size(geo_cfg.y_size)) begin
                    pos_y = 0;
                    pos_z++;
                    if (pos_z >= MAX_DIM) pos_z = 0;
                end
            end
        end
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // Idling before the next write keeps back-to-back writes apart.
        @(posedge i_clk);
        case (idx)
            REG_X_SIZE: geo_cfg.x_size = data[SIZE_W-1:0];
            REG_Y_SIZE: geo_cfg.y_size = data[SIZE_W-1:0];
            REG_PT_X:   line_cfg.pt_x  = data[PT_W-1:0];
            REG_PT_Y:   line_cfg.pt_y  = data[PT_W-1:0];
            REG_PT_Z:   line_cfg.pt_z  = data[PT_W-1:0];
            REG_DIR_X:  line_cfg.dir_x = data[DIR_W-1:0];
            REG_DIR_Y:  line_cfg.dir_y = data[DIR_W-1:0];
            REG_DIR_Z:  line_cfg.dir_z = data[DIR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_line(input int xs, input int ys, input int px, input int py,
                            input int pz, input int nx, input int ny, input int nz);
        write_reg(REG_X_SIZE, 32'(xs));
        write_reg(REG_Y_SIZE, 32'(ys));
        write_reg(REG_PT_X, 32'(px));
        write_reg(REG_PT_Y, 32'(py));
        write_reg(REG_PT_Z, 32'(pz));
        write_reg(REG_DIR_X, 32'(nx));
        write_reg(REG_DIR_Y, 32'(ny));
        write_reg(REG_DIR_Z, 32'(nz));
    endtask

    // A valid that stays up for the next request is not lowered in between.
    task automatic send_voxel(input logic [VAL_W-1:0] value, input logic last);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            vox_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vox_if.valid       <= 1'b1;
        vox_if.voxel_value <= value;
        vox_if.last_voxel  <= last;
        do @(posedge i_clk); while (!vox_if.ready);
        accumulate_voxel(value, last);
    endtask

    task automatic send_volume(input int count);
        for (int i = 0; i < count; i++) begin
            send_voxel(VAL_W'($urandom_range(0, 255)), i == count - 1);
        end
    endtask

    task automatic wait_sums_drained();
        vox_if.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: checks every accepted sum and drives ready with random stalls.
    initial begin : sum_sink
        int gap_left;
        int hold_left;
        int seen_hold;
        logic [SUM_W-1:0] want;
        gap_left  = 0;
        hold_left = 0;
        seen_hold = 0;
        sum_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sum_if.valid && sum_if.ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: line_sum %0d arrived with none expected", $time,
                             sum_if.line_sum);
                    fail_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (sum_if.line_sum !== want) begin
                        $display("%0t: line_sum mismatch: expected %0d, actual %0d",
                                 $time, want, sum_if.line_sum);
                        fail_count++;
                    end
                end
            end
            if (hold_seq != seen_hold) begin
                seen_hold = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                sum_if.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                sum_if.ready <= 1'b0;
            end else begin
                sum_if.ready <= 1'b1;
                gap_left = sink_idle_en ? pick_gap() : 0;
            end
        end
    end

    // Default line runs along x through the origin, so row zero counts.
    task automatic test_reset_defaults();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_voxel(8'hFF, 1'b0);
        send_voxel(8'h00, 1'b0);
        send_voxel(8'h01, 1'b0);
        send_voxel(8'h80, 1'b1);
        send_voxel(8'hFF, 1'b1);
        wait_sums_drained();
    endtask

    // Many one- or two-voxel volumes against a long receiver stall fill the block.
    task automatic test_output_backpressure();
        src_idle_en = 1'b0;
        hold_len    = 300;
        hold_seq++;
        repeat (40) send_volume($urandom_range(1, 2));
        wait_sums_drained();
        src_idle_en = 1'b1;
    endtask

    task automatic test_zero_sizes_and_extremes();
        // Zero sizes wrap x and y on every voxel; a zero direction leaves the
        // plain distance to the point, so only z = 2 and z = 3 count.
        set_line(0, 0, 0, 0, 640, 0, 0, 0);
        send_voxel(8'hFF, 1'b0);
        send_voxel(8'h01, 1'b0);
        send_voxel(8'hA5, 1'b0);
        send_voxel(8'h5A, 1'b0);
        send_voxel(8'h80, 1'b0);
        send_voxel(8'h7F, 1'b1);
        wait_sums_drained();
        set_line(1024, 1, 524287, -524288, -524288, -16384, 16384, -16384);
        send_voxel(8'hFF, 1'b0);
        send_voxel(8'hFF, 1'b0);
        send_voxel(8'hFF, 1'b1);
        wait_sums_drained();
        // Negative unit direction through a half-voxel point in a 2x2 slice.
        set_line(2, 2, 128, 256, 0, -16384, 0, 0);
        send_volume(8);
        wait_sums_drained();
    endtask

    task automatic test_counter_wraps();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        // Row size above the limit: x wraps after the last coordinate anyway,
        // and the zero slice size then moves z on, off the line.
        set_line(2047, 0, 0, 0, 0, 16384, 0, 0);
        send_volume(WRAP_VOXELS);
        wait_sums_drained();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    function automatic int pick_point(int size);
        int span;
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, (1 << PT_W) - 1));
        span = (size > 16) ? 16 : size;
        return int'($urandom_range(0, span - 1)) * 256 + int'($urandom_range(0, 511)) - 256;
    endfunction

    function automatic int pick_dir_part();
        int mag;
        case ($urandom_range(0, 4))
            0: mag = 0;
            1: mag = 16384;
            2: mag = 11585;
            3: mag = 9459;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic test_random_lines();
        int sent, xs, ys, nx, ny, nz, axis, full, count;
        sent = 0;
        while (sent < RANDOM_VOXELS) begin
            wait_sums_drained();
            xs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 6);
            ys = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 6);
            case ($urandom_range(0, 2))
                0: begin
                    axis = $urandom_range(0, 2);
                    nx = (axis == 0) ? 16384 : 0;
                    ny = (axis == 1) ? 16384 : 0;
                    nz = (axis == 2) ? 16384 : 0;
                    if ($urandom_range(0, 1)) begin
                        nx = -nx;
                        ny = -ny;
                        nz = -nz;
                    end
                end
                1: begin
                    nx = pick_dir_part();
                    ny = pick_dir_part();
                    nz = pick_dir_part();
                end
                default: begin
                    nx = $urandom_range(0, 1) ? -9459 : 9459;
                    ny = $urandom_range(0, 1) ? -9459 : 9459;
                    nz = $urandom_range(0, 1) ? -9459 : 9459;
                end
            endcase
            set_line(xs, ys, pick_point(eff_size(SIZE_W'(xs))),
                     pick_point(eff_size(SIZE_W'(ys))), pick_point(4), nx, ny, nz);
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5)) begin
                full = eff_size(geo_cfg.x_size) * eff_size(geo_cfg.y_size)
                       * $urandom_range(1, 4);
                // Mostly whole volumes; some requests end a volume early or late.
                if (full > 150 || $urandom_range(0, 4) == 0) count = $urandom_range(1, 40);
                else count = full;
                send_volume(count);
                sent += count;
            end
        end
        wait_sums_drained();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        vox_if.valid       = 1'b0;
        vox_if.voxel_value = '0;
        vox_if.last_voxel  = 1'b0;
        fail_count         = 0;
        hold_seq           = 0;
        hold_len           = 0;
        src_idle_en        = 1'b1;
        sink_idle_en       = 1'b1;
        geo_cfg            = '{x_size: X_SIZE_RST, y_size: Y_SIZE_RST};
        line_cfg           = '{pt_x: '0, pt_y: '0, pt_z: '0,
                               dir_x: DIR_X_RST, dir_y: '0, dir_z: '0};
        pos_x              = 0;
        pos_y              = 0;
        pos_z              = 0;
        tube_sum           = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_output_backpressure();
        test_zero_sizes_and_extremes();
        test_counter_wraps();
        test_random_lines();

        if (fail_count == 0) begin
            $display("tb_volume_line_tube_sum: PASS");
        end else begin
            $display("tb_volume_line_tube_sum: FAIL");
        end
        $finish;
    end

endmodule
